>>> design/ppi_pkg.sv
// Shared types and constants for the mode-0 parallel port block.
// No dependencies; imported by every design file.
package ppi_pkg;

  localparam logic [1:0] ADDR_PORT_A  = 2'd0;
  localparam logic [1:0] ADDR_PORT_B  = 2'd1;
  localparam logic [1:0] ADDR_PORT_C  = 2'd2;
  localparam logic [1:0] ADDR_CONTROL = 2'd3;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam int CTRL_MODE_SET_BIT = 7;
  localparam int CTRL_DIR_A_BIT    = 4;
  localparam int CTRL_DIR_B_BIT    = 1;
  localparam int CTRL_DIR_CU_BIT   = 3;
  localparam int CTRL_DIR_CL_BIT   = 0;
  localparam int CTRL_BSR_VAL_BIT  = 0;

  typedef struct packed {
    logic       kind;
    logic [1:0] address;
    logic [7:0] write_data;
    logic [7:0] pins_a;
    logic [7:0] pins_b;
    logic [7:0] pins_c;
  } req_t;

  typedef struct packed {
    logic [7:0] bus_result;
    logic [7:0] drive_a;
    logic [7:0] drive_b;
    logic [7:0] drive_c;
    logic       input_a;
    logic       input_b;
    logic [1:0] input_c;
    logic       strobe_a;
    logic       strobe_b;
    logic       strobe_c;
  } rsp_t;

  typedef struct packed {
    logic [7:0] latch_a;
    logic [7:0] latch_b;
    logic [7:0] latch_c;
    logic [7:0] control_word;
    logic       dir_a;
    logic       dir_b;
    logic [1:0] dir_c;
  } state_t;

endpackage

>>> design/ppi_step.sv
// Combinational update of the port latches and control state for one bus item.
// Depends on ppi_pkg.
module ppi_step (
  input  ppi_pkg::state_t state,
  input  ppi_pkg::req_t   item,
  output ppi_pkg::state_t state_next,
  output ppi_pkg::rsp_t   result
);
  import ppi_pkg::*;

  logic       na;
  logic       nb;
  logic [1:0] nc;
  logic [2:0] bit_sel;
  logic [7:0] mask;
  logic [7:0] bus;
  logic       sa;
  logic       sb;
  logic       sc;

  always_comb begin
    state_next = state;
    bus        = item.write_data;
    sa         = 1'b0;
    sb         = 1'b0;
    sc         = 1'b0;
    na         = item.write_data[CTRL_DIR_A_BIT];
    nb         = item.write_data[CTRL_DIR_B_BIT];
    nc         = {item.write_data[CTRL_DIR_CU_BIT], item.write_data[CTRL_DIR_CL_BIT]};
    bit_sel    = item.write_data[3:1];
    mask       = 8'd1 << bit_sel;

    if (item.kind == KIND_READ) begin
      case (item.address)
        ADDR_PORT_A: begin
          if (state.dir_a) state_next.latch_a = item.pins_a;
          bus = state_next.latch_a;
        end
        ADDR_PORT_B: begin
          if (state.dir_b) state_next.latch_b = item.pins_b;
          bus = state_next.latch_b;
        end
        ADDR_PORT_C: begin
          if (state.dir_c != 2'd0) state_next.latch_c = item.pins_c;
          bus = state_next.latch_c;
        end
        default: begin
          bus = state.control_word;
        end
      endcase
    end else begin
      case (item.address)
        ADDR_PORT_A: begin
          state_next.latch_a = item.write_data;
          sa = !state.dir_a;
        end
        ADDR_PORT_B: begin
          state_next.latch_b = item.write_data;
          sb = !state.dir_b;
        end
        ADDR_PORT_C: begin
          state_next.latch_c = item.write_data;
          sc = (state.dir_c == 2'd0);
        end
        default: begin
          state_next.control_word = item.write_data;
          if (item.write_data[CTRL_MODE_SET_BIT]) begin
            if (na != state.dir_a) begin
              state_next.dir_a = na;
              if (na) state_next.latch_a = item.pins_a;
              else sa = 1'b1;
              bus = state_next.latch_a;
            end
            if (nb != state.dir_b) begin
              state_next.dir_b = nb;
              if (nb) state_next.latch_b = item.pins_b;
              else sb = 1'b1;
              bus = state_next.latch_b;
            end
            if (nc != state.dir_c) begin
              state_next.dir_c = nc;
              if (nc != 2'd0) state_next.latch_c = item.pins_c;
              else sc = 1'b1;
              bus = state_next.latch_c;
            end
          end else if (state.dir_c == 2'd0) begin
            if (item.write_data[CTRL_BSR_VAL_BIT]) state_next.latch_c = state.latch_c | mask;
            else state_next.latch_c = state.latch_c & ~mask;
            sc  = 1'b1;
            bus = state_next.latch_c;
          end
        end
      endcase
    end

    result.bus_result = bus;
    result.drive_a    = state_next.latch_a;
    result.drive_b    = state_next.latch_b;
    result.drive_c    = state_next.latch_c;
    result.input_a    = state_next.dir_a;
    result.input_b    = state_next.dir_b;
    result.input_c    = state_next.dir_c;
    result.strobe_a   = sa;
    result.strobe_b   = sb;
    result.strobe_c   = sc;
  end

endmodule

>>> design/programmable_parallel_io_mode0.sv
// Mode-0 parallel port block: three port latches and a control register.
// Depends on ppi_pkg and ppi_step.
//
// Usage:
//   req channel (req_valid, req_stall, req) carries one bus access per item:
//   read or write at address 0..3 together with the sampled pin levels.
//   rsp channel (rsp_valid, rsp_stall, rsp) returns one item per access: the
//   bus byte, the latches driven to the pins, port directions and strobes.
//   An item is taken on an edge where valid is high and stall is low.
// Timing:
//   An accepted item passes one input register, then one pass of decode
//   logic into the result register. Throughput is one item per cycle while
//   rsp_stall is low; the latch and control update is a single pass.
// Reset:
//   rst clears all latches, the control word and the directions (all ports
//   output), and empties both pipeline registers.
// Backpressure:
//   While rsp_stall holds a finished item, one further item is held in the
//   input register; req_stall rises only when both registers are full.
module programmable_parallel_io_mode0 (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ppi_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ppi_pkg::rsp_t  rsp
);
  import ppi_pkg::*;

  logic   s1_valid;
  req_t   s1_item;
  state_t state;
  state_t state_next;
  rsp_t   result;
  logic   advance;

  assign advance   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && rsp_valid && rsp_stall;

  ppi_step u_step (
    .state      (state),
    .item       (s1_item),
    .state_next (state_next),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1_item <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

endmodule

>>> design/ppi_checker.sv
// Port-level checks for the mode-0 parallel port block, bound to the top level.
// Depends on ppi_pkg and programmable_parallel_io_mode0.
module ppi_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input ppi_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input ppi_pkg::rsp_t rsp
);
  import ppi_pkg::*;

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("req item changed while stalled");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("rsp item changed while stalled");

  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !rsp_stall |-> !req_stall)
    else $error("req stalled without rsp backpressure");

  a_strobe_a_dir: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.strobe_a |-> !rsp.input_a)
    else $error("port A strobed while input");

  a_strobe_c_dir: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.strobe_c |-> rsp.input_c == 2'd0)
    else $error("port C strobed while input");

endmodule

bind programmable_parallel_io_mode0 ppi_checker u_ppi_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
